>>> src/lruat_pkg.sv
// shared types and constants of the aging timeout table
`timescale 1ns / 1ps
`default_nettype none

package lruat_pkg;

  localparam int ACTION_W  = 3;
  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int TIMEOUT_W = 16;
  localparam int TIME_W    = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd60;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_FIND   = 3'd1,
    ACT_BUMP   = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_TICK   = 3'd4,
    ACT_SWEEP  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ANSWER = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  typedef struct packed {
    logic    accept;
    logic    append;
    logic    tick;
    logic    scan_start;
    logic    scan_next;
    logic    rd_scan;
    logic    rd_shift;
    logic    shift_write;
    logic    bump_write;
    logic    drop_tail;
    logic    rd_head;
    logic    sweep_start;
    logic    report;
    logic    answer;
    status_t ans_status;
    logic    ans_found;
  } lruat_cmd_t;

  typedef struct packed {
    action_t action;
    logic    req_valid;
    logic    full;
    logic    empty;
    logic    scan_end;
    logic    key_hit;
    logic    shift_end;
    logic    expired;
    logic    out_free;
  } lruat_sts_t;

endpackage

`default_nettype wire

>>> src/lruat_if.sv
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface lruat_req_if import lruat_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);
endinterface

interface lruat_rsp_if import lruat_pkg::*;;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [KEY_W-1:0]    out_key;
  logic [COUNT_W-1:0]  count;
  logic                last;

  modport source (output valid, output result_kind, output status, output found,
                  output out_key, output count, output last, input ready);
  modport sink (input valid, input result_kind, input status, input found,
                input out_key, input count, input last, output ready);
endinterface

interface lruat_cfg_if import lruat_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

>>> src/lruat_dp.sv
// datapath: entry memory, ring pointers, clock, timeout and result register
`timescale 1ns / 1ps
`default_nettype none

module lruat_dp import lruat_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  lruat_req_if.sink  req,
  lruat_rsp_if.source rsp,
  lruat_cfg_if.sink  cfg,
  input  lruat_cmd_t cmd,
  output lruat_sts_t sts
);

  localparam int SKW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [SKW-1:0]    mem_key   [DEPTH];
  logic [TIME_W-1:0] mem_stamp [DEPTH];

  action_t              action_q;
  logic [SKW-1:0]       key_q;
  logic [TIMEOUT_W-1:0] timeout;
  logic [TIME_W-1:0]    cur_time;
  logic [PW-1:0]        head;
  logic [PW-1:0]        tail;
  logic [PW-1:0]        ptr;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        removed;
  logic [SKW-1:0]       rd_key;
  logic [TIME_W-1:0]    rd_stamp;

  logic [PW-1:0]     head_inc, tail_inc, tail_dec, ptr_inc;
  logic              rd_en, wr_en;
  logic [PW-1:0]     rd_addr, wr_addr;
  logic [SKW-1:0]    wr_key;
  logic [TIME_W-1:0] wr_stamp;
  logic [TIME_W-1:0] age;

  logic                rsp_valid;
  kind_t               rsp_kind;
  status_t             rsp_status;
  logic                rsp_found;
  logic [KEY_W-1:0]    rsp_key;
  logic [COUNT_W-1:0]  rsp_count;
  logic                rsp_last;

  assign head_inc = (head == LAST_SLOT) ? '0 : head + PW'(1);
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + PW'(1);
  assign tail_dec = (tail == '0) ? LAST_SLOT : tail - PW'(1);
  assign ptr_inc  = (ptr == LAST_SLOT) ? '0 : ptr + PW'(1);

  assign rd_en   = cmd.rd_scan | cmd.rd_shift | cmd.rd_head;
  assign rd_addr = cmd.rd_shift ? ptr_inc : (cmd.rd_head ? head : ptr);

  assign wr_en    = cmd.append | cmd.shift_write | cmd.bump_write;
  assign wr_addr  = cmd.append ? tail : (cmd.shift_write ? ptr : tail_dec);
  assign wr_key   = cmd.shift_write ? rd_key : key_q;
  assign wr_stamp = cmd.shift_write ? rd_stamp : cur_time;

  assign age = cur_time - rd_stamp;

  // entry memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr]   <= wr_key;
      mem_stamp[wr_addr] <= wr_stamp;
    end
    if (rd_en) begin
      rd_key   <= mem_key[rd_addr];
      rd_stamp <= mem_stamp[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      action_q <= action_t'(req.action);
      key_q    <= req.key[SKW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RST;
    end else if (cfg.valid) begin
      timeout <= cfg.timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      ptr      <= '0;
      idx      <= '0;
      removed  <= '0;
    end else begin
      if (cmd.tick) begin
        cur_time <= cur_time + TIME_W'(1);
      end
      if (cmd.append) begin
        tail  <= tail_inc;
        count <= count + CW'(1);
      end
      if (cmd.drop_tail) begin
        tail  <= tail_dec;
        count <= count - CW'(1);
      end
      if (cmd.scan_start) begin
        ptr <= head;
        idx <= '0;
      end
      if (cmd.scan_next || cmd.shift_write) begin
        ptr <= ptr_inc;
        idx <= idx + CW'(1);
      end
      if (cmd.sweep_start) begin
        removed <= '0;
      end
      if (cmd.report) begin
        head    <= head_inc;
        count   <= count - CW'(1);
        removed <= removed + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.report || cmd.answer) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      rsp_kind   <= KIND_REPORT;
      rsp_status <= ST_OK;
      rsp_found  <= 1'b0;
      rsp_key    <= KEY_W'(rd_key);
      rsp_count  <= COUNT_W'(removed + CW'(1));
      rsp_last   <= 1'b0;
    end else if (cmd.answer) begin
      rsp_kind   <= KIND_ANSWER;
      rsp_status <= cmd.ans_status;
      rsp_found  <= cmd.ans_found;
      rsp_key    <= '0;
      rsp_count  <= (action_q == ACT_SWEEP) ? COUNT_W'(removed) : COUNT_W'(count);
      rsp_last   <= 1'b1;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.result_kind = rsp_kind;
  assign rsp.status      = rsp_status;
  assign rsp.found       = rsp_found;
  assign rsp.out_key     = rsp_key;
  assign rsp.count       = rsp_count;
  assign rsp.last        = rsp_last;

  assign req.ready = cmd.accept;
  assign cfg.ready = 1'b1;

  assign sts.action    = action_q;
  assign sts.req_valid = req.valid;
  assign sts.full      = (count == CW'(DEPTH));
  assign sts.empty     = (count == '0);
  assign sts.scan_end  = (idx == count);
  assign sts.key_hit   = (rd_key == key_q);
  assign sts.shift_end = ((idx + CW'(1)) == count);
  assign sts.expired   = (age >= TIME_W'(timeout));
  assign sts.out_free  = !rsp_valid || rsp.ready;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_ring_ends: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> (head == tail))
    else $error("ring pointers disagree with occupancy");

  a_report_on_sweep: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_kind == KIND_REPORT) |-> (action_q == ACT_SWEEP && !rsp_last))
    else $error("expired key report outside a sweep");

  a_time_on_tick: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && cur_time != $past(cur_time)) |-> $past(cmd.tick))
    else $error("clock advanced without a tick");
`endif

endmodule

`default_nettype wire

>>> src/lruat_ctrl.sv
// controller state machine: sequences scans, shifts, sweeps and answers
`timescale 1ns / 1ps
`default_nettype none

module lruat_ctrl import lruat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lruat_sts_t sts,
  output lruat_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EXEC   = 9'b000000010,
    S_SC_RD  = 9'b000000100,
    S_SC_CMP = 9'b000001000,
    S_SH_RD  = 9'b000010000,
    S_SH_WR  = 9'b000100000,
    S_SW_RD  = 9'b001000000,
    S_SW_CMP = 9'b010000000,
    S_ANS    = 9'b100000000
  } state_t;

  state_t  state, state_next;
  status_t res_status, res_status_next;
  logic    res_found, res_found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_found  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_found  <= res_found_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_found_next  = res_found;
    cmd             = '0;
    cmd.ans_status  = res_status;
    cmd.ans_found   = res_found;
    unique case (state)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (sts.req_valid) begin
          res_status_next = ST_OK;
          res_found_next  = 1'b0;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.action)
          ACT_INSERT: begin
            if (sts.full) begin
              res_status_next = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
            state_next = S_ANS;
          end
          ACT_FIND, ACT_BUMP, ACT_DELETE: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SC_RD;
          end
          ACT_TICK: begin
            cmd.tick   = 1'b1;
            state_next = S_ANS;
          end
          ACT_SWEEP: begin
            cmd.sweep_start = 1'b1;
            state_next      = S_SW_RD;
          end
          default: begin
            state_next = S_ANS;
          end
        endcase
      end
      S_SC_RD: begin
        if (sts.scan_end) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_ANS;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        if (sts.key_hit) begin
          if (sts.action == ACT_FIND) begin
            res_found_next = 1'b1;
            state_next     = S_ANS;
          end else begin
            state_next = S_SH_RD;
          end
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SC_RD;
        end
      end
      S_SH_RD: begin
        if (sts.shift_end) begin
          if (sts.action == ACT_BUMP) begin
            cmd.bump_write = 1'b1;
          end else begin
            cmd.drop_tail = 1'b1;
          end
          state_next = S_ANS;
        end else begin
          cmd.rd_shift = 1'b1;
          state_next   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.shift_write = 1'b1;
        state_next      = S_SH_RD;
      end
      S_SW_RD: begin
        if (sts.empty) begin
          state_next = S_ANS;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = S_SW_CMP;
        end
      end
      S_SW_CMP: begin
        if (!sts.expired) begin
          state_next = S_ANS;
        end else if (sts.out_free) begin
          cmd.report = 1'b1;
          state_next = S_SW_RD;
        end
      end
      S_ANS: begin
        if (sts.out_free) begin
          cmd.answer = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.req_valid) |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.report || cmd.answer) |-> sts.out_free)
    else $error("result loaded into a busy output register");

  a_one_memory_op: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.append, cmd.shift_write, cmd.bump_write}) <= 1)
    else $error("two memory writes in one cycle");
`endif

endmodule

`default_nettype wire

>>> src/lru_aging_timeout_table.sv
// top level of the aging timeout table
`timescale 1ns / 1ps
`default_nettype none

// Holds up to DEPTH keys oldest to newest in a ring memory with one write and one
// registered read port, each key stamped with the tick count. One request beat is
// taken at a time and yields one answer beat, or for sweep one beat per expired key
// and a final answer. Find, bump and delete compare entries from the oldest end
// up to the match; bump and delete then move each newer entry down to close the
// gap. Sweep examines entries from the oldest end. The pace is set by the single
// memory read port and its registered read data; a stalled response adds wait
// cycles. Timeout writes are taken at any time and should be made idle.
module lru_aging_timeout_table import lruat_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  lruat_req_if.sink   req,
  lruat_rsp_if.source rsp,
  lruat_cfg_if.sink   cfg
);

  lruat_cmd_t cmd;
  lruat_sts_t sts;

  lruat_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  lruat_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the lru aging timeout table
`timescale 1ns / 1ps

module testbench;
  import lruat_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int N_PHASES    = 5;
  localparam int PHASE_ITEMS = 50;
  localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 16;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic               found;
    logic [KEY_W-1:0]   out_key;
    logic [COUNT_W-1:0] count;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  reps;
    logic                typed;
    status_t             st;
    logic                found;
    logic [COUNT_W-1:0]  cnt;
  } stim_row_t;

  logic clk;
  logic rst;

  lruat_req_if req_ch ();
  lruat_rsp_if rsp_ch ();
  lruat_cfg_if cfg_ch ();

  lru_aging_timeout_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [KEY_W-1:0]     held_keys [$];
  logic [TIME_W-1:0]    held_stamps [$];
  logic [TIME_W-1:0]    tick_count;
  logic [TIMEOUT_W-1:0] expire_age;
  beat_t                owed_beats [$];
  logic [KEY_W-1:0]     key_pool [6];

  int send_gap_pct;
  int sink_stall_pct;
  int mismatches;
  int items_sent;
  int beats_checked;
  int reports_seen;

  // extremes, every action, duplicates, full table and absent keys
  stim_row_t directed_rows [15] = '{
    '{ACT_FIND,     32'h0000_0000, 5'd1,  1'b1, ST_NOT_FOUND, 1'b0, 5'd0},
    '{ACT_SWEEP,    32'h0000_0000, 5'd1,  1'b1, ST_OK,        1'b0, 5'd0},
    '{ACT_INSERT,   32'h0000_0000, 5'd1,  1'b1, ST_OK,        1'b0, 5'd1},
    '{ACT_INSERT,   32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,        1'b0, 5'd2},
    '{ACT_INSERT,   32'h0000_0000, 5'd1,  1'b1, ST_OK,        1'b0, 5'd3},
    '{ACT_FIND,     32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,        1'b1, 5'd3},
    '{ACT_BUMP,     32'h0000_0000, 5'd1,  1'b0, ST_OK,        1'b0, 5'd0},
    '{ACT_SPARE_LO, 32'h5A5A_A5A5, 5'd1,  1'b1, ST_OK,        1'b0, 5'd3},
    '{ACT_SPARE_HI, 32'hFFFF_0000, 5'd1,  1'b1, ST_OK,        1'b0, 5'd3},
    '{ACT_TICK,     32'h0000_0000, 5'd1,  1'b1, ST_OK,        1'b0, 5'd3},
    '{ACT_INSERT,   32'h1000_0001, 5'd13, 1'b0, ST_OK,        1'b0, 5'd0},
    '{ACT_INSERT,   32'h8000_0000, 5'd1,  1'b1, ST_FULL,      1'b0, 5'd16},
    '{ACT_DELETE,   32'h1234_5678, 5'd1,  1'b1, ST_NOT_FOUND, 1'b0, 5'd16},
    '{ACT_DELETE,   32'h0000_0000, 5'd1,  1'b0, ST_OK,        1'b0, 5'd0},
    '{ACT_SWEEP,    32'h0000_0000, 5'd1,  1'b0, ST_OK,        1'b0, 5'd0}
  };

  int               send_gap_plan   [N_PHASES] = '{0, 82, 0, 9, 0};
  int               sink_stall_plan [N_PHASES] = '{0, 0, 82, 9, 0};
  logic [TIMEOUT_W-1:0] timeout_plan [N_PHASES] = '{16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd6};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("lru_aging_timeout_table verification failed");
    $finish;
  end

  function automatic void owe_beat(input kind_t kind, input status_t st, input logic fnd,
                                   input logic [KEY_W-1:0] k, input logic [COUNT_W-1:0] cnt,
                                   input logic lst);
    owed_beats.push_back('{kind, st, fnd, k, cnt, lst});
  endfunction

  task automatic age_table_step(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
    int                 hit;
    logic [TIME_W-1:0]  age;
    logic [COUNT_W-1:0] removed;
    hit = -1;
    removed = '0;
    for (int i = 0; i < held_keys.size(); i++) begin
      if (hit < 0 && held_keys[i] == k) hit = i;
    end
    case (act)
      ACT_INSERT: begin
        if (held_keys.size() >= TABLE_DEPTH) begin
          owe_beat(KIND_ANSWER, ST_FULL, 1'b0, '0, COUNT_W'(held_keys.size()), 1'b1);
        end else begin
          held_keys.push_back(k);
          held_stamps.push_back(tick_count);
          owe_beat(KIND_ANSWER, ST_OK, 1'b0, '0, COUNT_W'(held_keys.size()), 1'b1);
        end
      end
      ACT_FIND: begin
        owe_beat(KIND_ANSWER, (hit < 0) ? ST_NOT_FOUND : ST_OK, hit >= 0, '0,
                 COUNT_W'(held_keys.size()), 1'b1);
      end
      ACT_BUMP, ACT_DELETE: begin
        if (hit < 0) begin
          owe_beat(KIND_ANSWER, ST_NOT_FOUND, 1'b0, '0, COUNT_W'(held_keys.size()), 1'b1);
        end else begin
          held_keys.delete(hit);
          held_stamps.delete(hit);
          if (act == ACT_BUMP) begin
            held_keys.push_back(k);
            held_stamps.push_back(tick_count);
          end
          owe_beat(KIND_ANSWER, ST_OK, 1'b0, '0, COUNT_W'(held_keys.size()), 1'b1);
        end
      end
      ACT_TICK: begin
        tick_count = tick_count + 1'b1;
        owe_beat(KIND_ANSWER, ST_OK, 1'b0, '0, COUNT_W'(held_keys.size()), 1'b1);
      end
      ACT_SWEEP: begin
        while (held_keys.size() != 0) begin
          age = tick_count - held_stamps[0];
          if (age < TIME_W'(expire_age)) break;
          removed = removed + 1'b1;
          owe_beat(KIND_REPORT, ST_OK, 1'b0, held_keys[0], removed, 1'b0);
          void'(held_keys.pop_front());
          void'(held_stamps.pop_front());
        end
        owe_beat(KIND_ANSWER, ST_OK, 1'b0, '0, removed, 1'b1);
      end
      default: begin
        owe_beat(KIND_ANSWER, ST_OK, 1'b0, '0, COUNT_W'(held_keys.size()), 1'b1);
      end
    endcase
  endtask

  task automatic send_op(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.key    <= k;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    age_table_step(act, k);
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.timeout_ticks <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    expire_age = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    k;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 30)      act = ACT_INSERT;
      else if (pick < 45) act = ACT_FIND;
      else if (pick < 57) act = ACT_BUMP;
      else if (pick < 69) act = ACT_DELETE;
      else if (pick < 87) act = ACT_TICK;
      else if (pick < 97) act = ACT_SWEEP;
      else if (pick < 99) act = ACT_SPARE_LO;
      else                act = ACT_SPARE_HI;
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(5)] : $urandom;
      send_op(act, k);
    end
  endtask

  task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_beats.size() == 0) begin
        mismatches++;
        $display("%0t: response beat with nothing outstanding, expected none, got kind %0d key %0h count %0d",
                 $time, rsp_ch.result_kind, rsp_ch.out_key, rsp_ch.count);
      end else begin
        want = owed_beats.pop_front();
        check_field("result_kind", KEY_W'(want.kind), KEY_W'(rsp_ch.result_kind));
        check_field("status", KEY_W'(want.status), KEY_W'(rsp_ch.status));
        check_field("found", KEY_W'(want.found), KEY_W'(rsp_ch.found));
        check_field("out_key", want.out_key, rsp_ch.out_key);
        check_field("count", KEY_W'(want.count), KEY_W'(rsp_ch.count));
        check_field("last", KEY_W'(want.last), KEY_W'(rsp_ch.last));
        beats_checked++;
        if (rsp_ch.result_kind == KIND_REPORT) reports_seen++;
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.action        = ACT_INSERT;
    req_ch.key           = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.timeout_ticks = TIMEOUT_RST;
    tick_count           = '0;
    expire_age           = TIMEOUT_RST;
    send_gap_pct         = 0;
    sink_stall_pct       = 0;
    mismatches           = 0;
    items_sent           = 0;
    beats_checked        = 0;
    reports_seen         = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    timeout_plan[3] = TIMEOUT_W'($urandom_range(12, 2));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        send_op(directed_rows[r].act, directed_rows[r].key + KEY_W'(i));
        if (directed_rows[r].typed) begin
          owed_beats[owed_beats.size() - 1] = '{KIND_ANSWER, directed_rows[r].st,
                                                directed_rows[r].found, '0,
                                                directed_rows[r].cnt, 1'b1};
        end
      end
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      send_gap_pct   = send_gap_plan[p];
      sink_stall_pct = sink_stall_plan[p];
      key_pool[p % 6] = $urandom;
      write_timeout(timeout_plan[p]);
      run_random(PHASE_ITEMS);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests over %0d timeout settings, %0d response beats compared",
             items_sent, N_PHASES + 1, beats_checked);
    $display("%0d expired keys reported by sweeps, %0d mismatches", reports_seen, mismatches);
    if (mismatches == 0 && owed_beats.size() == 0) begin
      $display("lru_aging_timeout_table verification clean");
    end else begin
      $display("lru_aging_timeout_table verification failed");
    end
    $finish;
  end

endmodule

>>> lru_aging_timeout_table.f
src/lruat_pkg.sv
src/lruat_if.sv
src/lruat_dp.sv
src/lruat_ctrl.sv
src/lru_aging_timeout_table.sv
tb/testbench.sv
